// File: hdl/stdpw_pkg.sv
// Shared constants, types and the decay ROM for the STDP synapse weight update block.
package stdpw_pkg;

   // Default widths handed to the top level
   localparam int TIME_BITS_DEF   = 32;
   localparam int WEIGHT_BITS_DEF = 24;

   // Fixed arithmetic widths
   localparam int TAU_W     = 16;              // time constant width
   localparam int FRAC_BITS = 16;              // Q16 fraction of the decay factor
   localparam int Q_W       = 21;              // quotient |dt|*2^16/tau width
   localparam int NUM_HI_W  = Q_W - FRAC_BITS; // dt bits that enter below the remainder
   localparam int CNT_W     = $clog2(Q_W);
   localparam int ACC_W     = 31;              // exp accumulator, at most 2^30
   localparam int ROM_W     = 30;
   localparam int FACTOR_W  = 17;              // Q16 factor, at most 65536
   localparam int MUL_B_W   = 32;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_WEIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_POT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TAU_POT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TAU_DEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_W_FLOOR     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_W_CEILING   = 3'd6;

   // Register reset values
   localparam int INIT_WEIGHT_RST = 65536;
   localparam int GAIN_POT_RST    = 655;
   localparam int GAIN_DEP_RST    = -655;
   localparam int TAU_POT_RST     = 20;
   localparam int TAU_DEP_RST     = 20;
   localparam int W_FLOOR_RST     = 0;
   localparam int W_CEILING_RST   = 327680;

   // round(exp(-2^(b-16)) * 2^30) for quotient bit b
   localparam logic [ROM_W-1:0] EXP_ROM [Q_W] = '{
      30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760, 30'd1073479712,
      30'd1073217664, 30'd1072693760, 30'd1071646719, 30'd1069555701, 30'd1065385899,
      30'd1057095000, 30'd1040706261, 30'd1008687096, 30'd947573834,  30'd836230973,
      30'd651257337,  30'd395007542,  30'd145315154,  30'd19666268,   30'd360200,
      30'd121
   };

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EXP_SCAN,
      ST_EXP_ACC,
      ST_GAIN_MUL,
      ST_GAIN_ACC,
      ST_FINISH
   } seq_state_type;

   // Divider start command
   typedef struct packed {
      logic                start;
      logic [TAU_W-1:0]    rem_init;
      logic [NUM_HI_W-1:0] num_init;
      logic [TAU_W-1:0]    divisor;
   } div_cmd_type;

endpackage

// File: hdl/stdp_synapse_weight_update.sv
// Top level: pair-based STDP inhibitory synapse with an iterative fixed-point update.
//
// Use: one spike event is a beat on the req_ channel (valid/stall). A beat is taken
// only while the sequencer is idle; req_stall is high for the whole update. Each
// event gives exactly one rsp_ beat: the injected current (negated old weight on a
// pre event), the new weight and a changed flag. The rsp_ side has its own output
// register, so a new event may be taken while the previous result is still stalled;
// the finishing update then waits until that register is free.
// With no exponential (a time is missing, equal times, or |dt| >= 32*tau) the
// sequencer goes from PREP straight to FINISH. Otherwise the divider runs first, then
// the exp loop scans each quotient bit and adds an accumulate step per set bit (1 to
// 21 set bits), all through the one shared multiplier, and the gain multiply follows;
// the next event is taken once FINISH hands over the result. Configuration is written
// through csr_; the user must write it only while idle, as the block itself does not
// enforce it. A write of initial_weight also loads the weight at once. Reset
// (synchronous) restores the register defaults and loads the weight with 1.0. A
// stalled result holds its beat until taken.
module stdp_synapse_weight_update import stdpw_pkg::*; #(
   parameter int  TIME_BITS   = TIME_BITS_DEF,
   parameter int  WEIGHT_BITS = WEIGHT_BITS_DEF,
   localparam int CSR_W       = (WEIGHT_BITS > TAU_W) ? WEIGHT_BITS : TAU_W
) (
   input  logic                          clock,
   input  logic                          reset,
   // spike event channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [TIME_BITS-1:0]          req_pre_spike_time,
   input  logic [TIME_BITS-1:0]          req_post_spike_time,
   input  logic                          req_pre_has_spiked,
   input  logic                          req_post_has_spiked,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [WEIGHT_BITS-1:0] rsp_injected_current,
   output logic                          rsp_current_valid,
   output logic signed [WEIGHT_BITS-1:0] rsp_new_weight,
   output logic                          rsp_weight_changed,
   // configuration writes
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   localparam int W       = WEIGHT_BITS;
   localparam int SUM_W   = W + 2;
   localparam int MUL_A_W = (W > 32) ? W : 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int CMP_W   = (TIME_BITS > Q_W) ? TIME_BITS : Q_W;
   localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};

   // Configuration registers
   logic signed [W-1:0] gain_pot_ff, gain_dep_ff, floor_ff, ceiling_ff;
   logic [TAU_W-1:0]    tau_pot_ff, tau_dep_ff;
   logic signed [W-1:0] weight_ff, weight_in;

   // Sequencer and datapath registers
   seq_state_type           state_ff, state_in;
   logic                    is_pre_ff, is_pre_in;
   logic                    clamp_en_ff, clamp_en_in;
   logic                    dir_pos_ff, dir_pos_in;
   logic [TIME_BITS-1:0]    pre_t_ff, pre_t_in;
   logic [TIME_BITS-1:0]    post_t_ff, post_t_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]        bit_ff, bit_in;
   logic signed [SUM_W-1:0] delta_ff, delta_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]     rsp_current_ff, rsp_current_in;
   logic                    rsp_cur_valid_ff, rsp_cur_valid_in;
   logic signed [W-1:0]     rsp_weight_ff, rsp_weight_in;
   logic                    rsp_changed_ff, rsp_changed_in;

   // Shared units
   div_cmd_type                div_cmd;
   logic                       div_done;
   logic [Q_W-1:0]             div_quot;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;

   // Combinational helpers
   logic                    req_fire, fin_fire;
   logic [TIME_BITS-1:0]    dt;
   logic [CMP_W-1:0]        dt_ext, dt_lim;
   logic [TAU_W-1:0]        tau_raw, tau_eff;
   logic [ACC_W:0]          fac_sum;
   logic [FACTOR_W-1:0]     factor;
   logic signed [PROD_W-1:0] acc_round, gain_round;
   logic signed [W-1:0]     gain_sel;
   logic signed [SUM_W-1:0] sum, floor_x, ceiling_x;
   logic signed [W-1:0]     new_w, cur_w;

   stdpw_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   stdpw_mul #(.MUL_A_W(MUL_A_W)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fin_fire  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Delay magnitude, direction and range check for the captured event
   always_comb begin
      dir_pos_in = post_t_ff > pre_t_ff;
      dt         = dir_pos_in ? (post_t_ff - pre_t_ff) : (pre_t_ff - post_t_ff);
      tau_raw    = dir_pos_in ? tau_pot_ff : tau_dep_ff;
      tau_eff    = (tau_raw == '0) ? TAU_W'(1) : tau_raw;
      dt_ext     = CMP_W'(dt);
      dt_lim     = CMP_W'({tau_eff, 5'b00000});
   end

   // Rounding of the shared product and Q16 factor
   always_comb begin
      fac_sum    = {1'b0, acc_ff} + (ACC_W+1)'(1 << (ACC_W - FACTOR_W - 1));
      factor     = fac_sum[ACC_W-1:ACC_W-FACTOR_W];
      acc_round  = prod + PROD_W'(64'd1 << 29);
      gain_round = prod + PROD_W'(64'd1 << (FRAC_BITS - 1));
      gain_sel   = dir_pos_ff ? gain_pot_ff : gain_dep_ff;
   end

   // Weight update, clamp and current
   always_comb begin
      floor_x   = SUM_W'(floor_ff);
      ceiling_x = SUM_W'(ceiling_ff);
      sum       = SUM_W'(weight_ff) + delta_ff;
      if (!clamp_en_ff) begin
         new_w = weight_ff;
      end else if (sum < floor_x) begin
         new_w = floor_ff;
      end else if (sum > ceiling_x) begin
         new_w = ceiling_ff;
      end else begin
         new_w = sum[W-1:0];
      end
      if (!is_pre_ff) begin
         cur_w = '0;
      end else if (weight_ff == W_MIN) begin
         cur_w = W_MAX;
      end else begin
         cur_w = -weight_ff;
      end
   end

   // Sequencer: next state, unit operands and datapath next values
   always_comb begin
      state_in         = state_ff;
      is_pre_in        = is_pre_ff;
      clamp_en_in      = clamp_en_ff;
      pre_t_in         = pre_t_ff;
      post_t_in        = post_t_ff;
      acc_in           = acc_ff;
      bit_in           = bit_ff;
      delta_in         = delta_ff;
      div_cmd.start    = 1'b0;
      div_cmd.rem_init = dt_ext[Q_W-1:NUM_HI_W];
      div_cmd.num_init = dt_ext[NUM_HI_W-1:0];
      div_cmd.divisor  = tau_eff;
      mul_a            = signed'(MUL_A_W'(acc_ff));
      mul_b            = signed'(MUL_B_W'(EXP_ROM[bit_ff]));
      weight_in        = weight_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_current_in   = rsp_current_ff;
      rsp_cur_valid_in = rsp_cur_valid_ff;
      rsp_weight_in    = rsp_weight_ff;
      rsp_changed_in   = rsp_changed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_pre_in   = !req_kind;
               clamp_en_in = req_pre_has_spiked && req_post_has_spiked;
               pre_t_in    = req_pre_spike_time;
               post_t_in   = req_post_spike_time;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            delta_in = '0;
            acc_in   = ACC_W'(1 << 30);
            bit_in   = '0;
            if (!clamp_en_ff || dt == '0 || dt_ext >= dt_lim) begin
               state_in = ST_FINISH;
            end else begin
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EXP_SCAN;
            end
         end
         ST_EXP_SCAN: begin
            if (div_quot[bit_ff]) begin
               state_in = ST_EXP_ACC;
            end else if (bit_ff == CNT_W'(Q_W - 1)) begin
               state_in = ST_GAIN_MUL;
            end else begin
               bit_in = bit_ff + 1'b1;
            end
         end
         ST_EXP_ACC: begin
            acc_in = acc_round[30+ACC_W-1:30];
            if (bit_ff == CNT_W'(Q_W - 1)) begin
               state_in = ST_GAIN_MUL;
            end else begin
               bit_in   = bit_ff + 1'b1;
               state_in = ST_EXP_SCAN;
            end
         end
         ST_GAIN_MUL: begin
            mul_a    = MUL_A_W'(gain_sel);
            mul_b    = signed'(MUL_B_W'(factor));
            state_in = ST_GAIN_ACC;
         end
         ST_GAIN_ACC: begin
            delta_in = gain_round[FRAC_BITS+SUM_W-1:FRAC_BITS];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fin_fire) begin
               weight_in        = new_w;
               rsp_valid_in     = 1'b1;
               rsp_current_in   = cur_w;
               rsp_cur_valid_in = is_pre_ff;
               rsp_weight_in    = new_w;
               rsp_changed_in   = (new_w != weight_ff);
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration registers and the weight
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_pot_ff    <= W'(GAIN_POT_RST);
         gain_dep_ff    <= W'(GAIN_DEP_RST);
         tau_pot_ff     <= TAU_W'(TAU_POT_RST);
         tau_dep_ff     <= TAU_W'(TAU_DEP_RST);
         floor_ff       <= W'(W_FLOOR_RST);
         ceiling_ff     <= W'(W_CEILING_RST);
         weight_ff      <= W'(INIT_WEIGHT_RST);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_INIT_WEIGHT: begin
               weight_ff      <= csr_wdata[W-1:0];
            end
            REG_GAIN_POT:  gain_pot_ff <= csr_wdata[W-1:0];
            REG_GAIN_DEP:  gain_dep_ff <= csr_wdata[W-1:0];
            REG_TAU_POT:   tau_pot_ff  <= csr_wdata[TAU_W-1:0];
            REG_TAU_DEP:   tau_dep_ff  <= csr_wdata[TAU_W-1:0];
            REG_W_FLOOR:   floor_ff    <= csr_wdata[W-1:0];
            REG_W_CEILING: ceiling_ff  <= csr_wdata[W-1:0];
            default: ;
         endcase
      end else begin
         weight_ff <= weight_in;
      end
   end

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_pre_ff        <= is_pre_in;
      clamp_en_ff      <= clamp_en_in;
      dir_pos_ff       <= (state_ff == ST_PREP) ? dir_pos_in : dir_pos_ff;
      pre_t_ff         <= pre_t_in;
      post_t_ff        <= post_t_in;
      acc_ff           <= acc_in;
      bit_ff           <= bit_in;
      delta_ff         <= delta_in;
      rsp_current_ff   <= rsp_current_in;
      rsp_cur_valid_ff <= rsp_cur_valid_in;
      rsp_weight_ff    <= rsp_weight_in;
      rsp_changed_ff   <= rsp_changed_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_injected_current = rsp_current_ff;
   assign rsp_current_valid    = rsp_cur_valid_ff;
   assign rsp_new_weight       = rsp_weight_ff;
   assign rsp_weight_changed   = rsp_changed_ff;

   // Divider finishes only while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside of divide state");

   // Decay accumulator never grows past 1.0
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP_SCAN || state_ff == ST_EXP_ACC) |-> acc_ff <= ACC_W'(1 << 30))
      else $error("exp accumulator above 2^30");

   // Weight moves only on a finished update or a write of initial_weight
   a_weight_hold: assert property (@(posedge clock) disable iff (reset)
      !fin_fire && !(csr_write && csr_index == REG_INIT_WEIGHT) |=> $stable(weight_ff))
      else $error("weight changed without an update");

   // Changed flag matches the weight before and after the event
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> rsp_weight_changed == (weight_ff != $past(weight_ff)))
      else $error("weight_changed flag inconsistent");

endmodule

// File: hdl/stdpw_div.sv
// Restoring divider, one quotient bit per cycle: q = (dt << 16) / tau.
module stdpw_div import stdpw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_cmd_type      cmd,
   output logic             done,
   output logic [Q_W-1:0]   quot
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TAU_W-1:0] rem_ff, rem_in;
   logic [TAU_W-1:0] div_ff, div_in;
   logic [Q_W-1:0]   shift_ff, shift_in;   // numerator bits out on top, quotient in below

   logic [TAU_W:0]   partial;
   logic [TAU_W+1:0] trial;
   logic             ge;

   // Trial subtract of the divisor
   always_comb begin
      partial = {rem_ff, shift_ff[Q_W-1]};
      trial   = {1'b0, partial} - {2'b00, div_ff};
      ge      = !trial[TAU_W+1];
   end

   // Step and start control
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      shift_in = shift_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = cmd.rem_init;
         div_in   = cmd.divisor;
         shift_in = {cmd.num_init, {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         rem_in   = ge ? trial[TAU_W-1:0] : partial[TAU_W-1:0];
         shift_in = {shift_ff[Q_W-2:0], ge};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      shift_ff <= shift_in;
   end

   assign done = done_ff;
   assign quot = shift_ff;

endmodule

// File: hdl/stdpw_mul.sv
// Shared signed multiplier with a registered product.
module stdpw_mul import stdpw_pkg::*; #(
   parameter int MUL_A_W = 32
) (
   input  logic                             clock,
   input  logic signed [MUL_A_W-1:0]         mul_a,
   input  logic signed [MUL_B_W-1:0]         mul_b,
   output logic signed [MUL_A_W+MUL_B_W-1:0] prod
);

   logic signed [MUL_A_W+MUL_B_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = (MUL_A_W+MUL_B_W)'(mul_a) * (MUL_A_W+MUL_B_W)'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
